### rtl/lemq_pkg.sv
// Shared types, widths and codes for the line envelope maximum query block.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
`default_nettype none

package lemq_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int LINE_SLOTS = 256;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = $clog2(LINE_SLOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int VAL_W      = 2 * DATA_W;
	localparam int NUM_W      = DATA_W + 1 + FRAC_BITS;
	localparam int DEN_W      = DATA_W + 1;
	localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
	localparam int LINE_W     = 3 * DATA_W;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_SLOPE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [2:0] RD_TOP      = 3'd0;
	localparam logic [2:0] RD_MID      = 3'd1;
	localparam logic [2:0] RD_LO       = 3'd2;
	localparam logic [2:0] RD_PTR_NEXT = 3'd3;
	localparam logic [2:0] RD_PTR      = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] slope;
		logic signed [DATA_W-1:0] offset;
		logic signed [DATA_W-1:0] start;
	} line_t;

	typedef struct packed {
		logic       load_in;
		logic       init;
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       div_start;
		logic       take_cross;
		logic       pop;
		logic       commit;
		logic       bs_update;
		logic       ptr_inc;
		logic       set_best_lo;
		logic       set_best_ptr;
		logic       mult;
		logic       add;
		logic       status_we;
		logic [1:0] status_code;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       depth_zero;
		logic       slope_le;
		logic       start_le_cross;
		logic       start_le_x;
		logic       bs_more;
		logic       pt_more;
		logic       d_full;
		logic       d_one;
		logic       div_done;
	} sts_t;

endpackage

`default_nettype wire

### rtl/lemq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module lemq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/lemq_div.sv
// Serial restoring divider for line intersections: floor quotient, saturated
// to the signed 32-bit range. One quotient bit per cycle. Uses lemq_pkg.
`default_nettype none

module lemq_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [lemq_pkg::NUM_W-1:0] num,
	input  wire logic        [lemq_pkg::DEN_W-1:0] den,
	output logic                                  done,
	output logic signed [lemq_pkg::DATA_W-1:0]    quot
);

	localparam int NW = lemq_pkg::NUM_W;
	localparam int DW = lemq_pkg::DEN_W;
	localparam int QW = lemq_pkg::DATA_W;

	logic                            busy_q;
	logic                            fin_q;
	logic [lemq_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [NW-1:0]                   mag_q;
	logic [DW:0]                     rem_q;
	logic [DW-1:0]                   den_q;
	logic                            neg_q;

	logic [DW:0]          rem_sh;
	logic [DW+1:0]        trial;
	logic                 ge;
	logic [NW-1:0]        num_abs;
	logic [NW:0]          q_mag;
	logic signed [NW:0]   q_signed;
	logic signed [NW:0]   q_max;
	logic signed [NW:0]   q_min;

	assign rem_sh  = {rem_q[DW-1:0], mag_q[NW-1]};
	assign trial   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge      = !trial[DW+1];
	assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);

	// Rounding toward minus infinity: a negative inexact quotient drops by one.
	assign q_mag    = {1'b0, mag_q} + (NW+1)'(neg_q && (rem_q != '0));
	assign q_signed = neg_q ? -$signed(q_mag) : $signed(q_mag);
	assign q_max    = (NW+1)'({1'b0, {(QW-1){1'b1}}});
	assign q_min    = -q_max - (NW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lemq_pkg::DIV_CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lemq_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num_abs;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NW-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[DW:0] : rem_sh;
			mag_q <= {mag_q[NW-2:0], ge};
		end else if (fin_q) begin
			if (q_signed > q_max) begin
				quot <= {1'b0, {(QW-1){1'b1}}};
			end else if (q_signed < q_min) begin
				quot <= {1'b1, {(QW-1){1'b0}}};
			end else begin
				quot <= q_signed[QW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lemq_dp.sv
// Datapath: line store, stack depth, scan pointer, search bounds, divider,
// multiplier and output register. Driven by lemq_ctrl; uses lemq_pkg,
// lemq_ram and lemq_div.
`default_nettype none

module lemq_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lemq_pkg::cmd_t                     cmd,
	output lemq_pkg::sts_t                          sts,
	input  wire logic [1:0]                         mode,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] slope,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] intercept,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] query_x,
	output logic signed [lemq_pkg::VAL_W-1:0]       envelope_value,
	output logic [lemq_pkg::IDX_W-1:0]              best_line,
	output logic [1:0]                              status,
	output logic [lemq_pkg::CNT_W-1:0]              hull_size
);

	localparam int DW = lemq_pkg::DATA_W;
	localparam int IW = lemq_pkg::IDX_W;
	localparam int CW = lemq_pkg::CNT_W;
	localparam int VW = lemq_pkg::VAL_W;

	logic [1:0]           mode_q;
	logic signed [DW-1:0] m_q;
	logic signed [DW-1:0] c_q;
	logic signed [DW-1:0] x_q;
	logic [CW-1:0]        depth_q;
	logic [IW-1:0]        ptr_q;
	logic [CW-1:0]        d_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [CW-1:0]        mid_q;
	logic signed [DW-1:0] start_q;
	logic signed [VW-1:0] prod_s1;
	logic signed [VW-1:0] value_q;
	logic [IW-1:0]        best_q;
	logic [1:0]           status_q;

	logic [lemq_pkg::LINE_W-1:0] rdata;
	lemq_pkg::line_t             rd_line;
	lemq_pkg::line_t             wr_line;
	logic [IW-1:0]               raddr;
	logic [CW:0]                 mid_sum;
	logic [CW-1:0]               mid;
	logic [CW-1:0]               ptr_next;
	logic [CW-1:0]               depth_m1;

	logic signed [lemq_pkg::NUM_W-1:0] div_num;
	logic [lemq_pkg::DEN_W-1:0]        div_den;
	logic signed [lemq_pkg::DEN_W-1:0] c_diff;
	logic signed [lemq_pkg::DEN_W-1:0] m_diff;
	logic                              div_done;
	logic signed [DW-1:0]              div_quot;
	logic signed [VW-1:0]              off_ext;

	assign rd_line  = lemq_pkg::line_t'(rdata);
	assign wr_line  = '{slope: m_q, offset: c_q, start: start_q};
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CW:1];
	assign ptr_next = {1'b0, ptr_q} + CW'(1);
	assign depth_m1 = depth_q - CW'(1);

	always_comb begin
		case (cmd.rd_sel)
			lemq_pkg::RD_TOP:      raddr = IW'(d_q - CW'(1));
			lemq_pkg::RD_MID:      raddr = mid[IW-1:0];
			lemq_pkg::RD_LO:       raddr = lo_q[IW-1:0];
			lemq_pkg::RD_PTR_NEXT: raddr = ptr_next[IW-1:0];
			default:               raddr = ptr_q;
		endcase
	end

	lemq_ram #(
		.WIDTH(lemq_pkg::LINE_W),
		.DEPTH(lemq_pkg::LINE_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(d_q[IW-1:0]),
		.wdata(wr_line),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Intersection numerator (c_top - c_new) scaled by the fraction and the
	// positive slope difference as denominator.
	assign c_diff  = lemq_pkg::DEN_W'(rd_line.offset) - lemq_pkg::DEN_W'(c_q);
	assign m_diff  = lemq_pkg::DEN_W'(m_q) - lemq_pkg::DEN_W'(rd_line.slope);
	assign div_num = {c_diff, {lemq_pkg::FRAC_BITS{1'b0}}};
	assign div_den = m_diff;

	lemq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign off_ext = VW'(rd_line.offset);

	always_comb begin
		sts.mode           = mode_q;
		sts.depth_zero     = (depth_q == '0);
		sts.slope_le       = (m_q <= rd_line.slope);
		sts.start_le_cross = (rd_line.start <= div_quot);
		sts.start_le_x     = (rd_line.start <= x_q);
		sts.bs_more        = ((lo_q + CW'(1)) < hi_q);
		sts.pt_more        = (ptr_next < depth_q);
		sts.d_full         = d_q[CW-1];
		sts.d_one          = (d_q == CW'(1));
		sts.div_done       = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.commit) begin
				depth_q <= d_q + CW'(1);
			end
			if (cmd.init && mode_q == lemq_pkg::MODE_SCAN && depth_q != '0
			    && {1'b0, ptr_q} > depth_m1) begin
				ptr_q <= depth_m1[IW-1:0];
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_next[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q   <= mode;
			m_q      <= slope;
			c_q      <= intercept;
			x_q      <= query_x;
			value_q  <= '0;
			best_q   <= '0;
			status_q <= lemq_pkg::ST_OK;
		end
		if (cmd.init) begin
			d_q     <= depth_q;
			lo_q    <= '0;
			hi_q    <= depth_q;
			start_q <= {1'b1, {(DW-1){1'b0}}};
		end
		if (cmd.rd_en && cmd.rd_sel == lemq_pkg::RD_MID) begin
			mid_q <= mid;
		end
		if (cmd.take_cross) begin
			start_q <= div_quot;
		end
		if (cmd.pop) begin
			d_q <= d_q - CW'(1);
		end
		if (cmd.bs_update) begin
			if (sts.start_le_x) begin
				lo_q <= mid_q;
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.commit) begin
			best_q <= d_q[IW-1:0];
		end
		if (cmd.set_best_lo) begin
			best_q <= lo_q[IW-1:0];
		end
		if (cmd.set_best_ptr) begin
			best_q <= ptr_q;
		end
		if (cmd.mult) begin
			prod_s1 <= rd_line.slope * x_q;
		end
		if (cmd.add) begin
			value_q <= prod_s1 + (off_ext <<< lemq_pkg::FRAC_BITS);
		end
		if (cmd.status_we) begin
			status_q <= cmd.status_code;
		end
		if (cmd.out_load) begin
			envelope_value <= value_q;
			best_line      <= best_q;
			status         <= status_q;
			hull_size      <= depth_q;
		end
	end

	// The stack never holds more lines than the store has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CW'(lemq_pkg::LINE_SLOTS))
		else $error("stack depth beyond the store size");

endmodule

`default_nettype wire

### rtl/lemq_ctrl.sv
// Controller state machine: sequences adds, pops, searches and evaluation,
// and owns both handshakes. Uses lemq_pkg; drives lemq_dp by command.
`default_nettype none

module lemq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire lemq_pkg::sts_t sts,
	output lemq_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_ADD_RD   = 4'd2;
	localparam logic [3:0] S_ADD_CHK  = 4'd3;
	localparam logic [3:0] S_ADD_DIV  = 4'd4;
	localparam logic [3:0] S_COMMIT   = 4'd5;
	localparam logic [3:0] S_BS_CHK   = 4'd6;
	localparam logic [3:0] S_BS_WAIT  = 4'd7;
	localparam logic [3:0] S_PT_CHK   = 4'd8;
	localparam logic [3:0] S_PT_WAIT  = 4'd9;
	localparam logic [3:0] S_EV_WAIT  = 4'd10;
	localparam logic [3:0] S_EV_ADD   = 4'd11;
	localparam logic [3:0] S_FINISH   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       in_xfer;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.init = 1'b1;
				if (sts.mode == lemq_pkg::MODE_ADD) begin
					state_d = sts.depth_zero ? S_COMMIT : S_ADD_RD;
				end else if (sts.mode == lemq_pkg::MODE_SEARCH
				             || sts.mode == lemq_pkg::MODE_SCAN) begin
					if (sts.depth_zero) begin
						cmd.status_we   = 1'b1;
						cmd.status_code = lemq_pkg::ST_EMPTY;
						state_d         = S_FINISH;
					end else begin
						state_d = (sts.mode == lemq_pkg::MODE_SEARCH) ? S_BS_CHK : S_PT_CHK;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_ADD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = lemq_pkg::RD_TOP;
				state_d    = S_ADD_CHK;
			end
			S_ADD_CHK: begin
				if (sts.slope_le) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = lemq_pkg::ST_SLOPE;
					state_d         = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_ADD_DIV;
				end
			end
			S_ADD_DIV: begin
				if (sts.div_done) begin
					if (sts.start_le_cross) begin
						cmd.take_cross = 1'b1;
						state_d        = S_COMMIT;
					end else begin
						cmd.pop = 1'b1;
						state_d = sts.d_one ? S_COMMIT : S_ADD_RD;
					end
				end
			end
			S_COMMIT: begin
				if (sts.d_full) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = lemq_pkg::ST_FULL;
				end else begin
					cmd.commit = 1'b1;
				end
				state_d = S_FINISH;
			end
			S_BS_CHK: begin
				cmd.rd_en = 1'b1;
				if (sts.bs_more) begin
					cmd.rd_sel = lemq_pkg::RD_MID;
					state_d    = S_BS_WAIT;
				end else begin
					cmd.rd_sel      = lemq_pkg::RD_LO;
					cmd.set_best_lo = 1'b1;
					state_d         = S_EV_WAIT;
				end
			end
			S_BS_WAIT: begin
				cmd.bs_update = 1'b1;
				state_d       = S_BS_CHK;
			end
			S_PT_CHK: begin
				cmd.rd_en = 1'b1;
				if (sts.pt_more) begin
					cmd.rd_sel = lemq_pkg::RD_PTR_NEXT;
					state_d    = S_PT_WAIT;
				end else begin
					cmd.rd_sel       = lemq_pkg::RD_PTR;
					cmd.set_best_ptr = 1'b1;
					state_d          = S_EV_WAIT;
				end
			end
			S_PT_WAIT: begin
				if (sts.start_le_x) begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_PT_CHK;
				end else begin
					cmd.rd_en        = 1'b1;
					cmd.rd_sel       = lemq_pkg::RD_PTR;
					cmd.set_best_ptr = 1'b1;
					state_d          = S_EV_WAIT;
				end
			end
			S_EV_WAIT: begin
				cmd.mult = 1'b1;
				state_d  = S_EV_ADD;
			end
			S_EV_ADD: begin
				cmd.add = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// A pending result is never overwritten before its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

	// An accepted item keeps the block busy on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("block idle right after accepting an item");

	// A new result appears only out of the finishing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FINISH))
		else $error("result raised outside the finishing state");

endmodule

`default_nettype wire

### rtl/line_envelope_max_query.sv
// Top level of the line envelope maximum query block (upper hull of lines).
// Depends on lemq_pkg, lemq_ctrl, lemq_dp (with lemq_ram and lemq_div).
//
//   Channel  Handshake            Payload
//   input    in_valid/in_stall    mode, slope, intercept, query_x
//   output   out_valid/out_stall  envelope_value, best_line, status, hull_size
//
// One item at a time. An add runs the serial divider (one quotient bit per
// cycle) once per stacked line it examines. A binary search query reads the
// store once per halving; a pointer query reads it once per advance, each
// step bound by the store read port.
// Reset clears the stack depth and scan pointer but not the line store;
// there is no clearing pass. A stalled result waits in the output register
// while the next item is taken in.
`default_nettype none

module line_envelope_max_query (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         mode,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] slope,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] intercept,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] query_x,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [lemq_pkg::VAL_W-1:0]       envelope_value,
	output logic [lemq_pkg::IDX_W-1:0]              best_line,
	output logic [1:0]                              status,
	output logic [lemq_pkg::CNT_W-1:0]              hull_size
);

	lemq_pkg::cmd_t cmd;
	lemq_pkg::sts_t sts;

	lemq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lemq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.slope         (slope),
		.intercept     (intercept),
		.query_x       (query_x),
		.envelope_value(envelope_value),
		.best_line     (best_line),
		.status        (status),
		.hull_size     (hull_size)
	);

endmodule

`default_nettype wire

### sim/line_envelope_max_query_checker.sv
// Checker for the line envelope maximum query block: watches both channels,
// keeps its own copy of the line stack, predicts each result and compares.
// Depends on lemq_pkg for widths and mode and status codes.
`default_nettype none

module line_envelope_max_query_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic [1:0]                         mode,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] slope,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] intercept,
	input  wire logic signed [lemq_pkg::DATA_W-1:0] query_x,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic signed [lemq_pkg::VAL_W-1:0]  envelope_value,
	input  wire logic [lemq_pkg::IDX_W-1:0]         best_line,
	input  wire logic [1:0]                         status,
	input  wire logic [lemq_pkg::CNT_W-1:0]         hull_size,
	output int                                      fail_count,
	output int                                      pending,
	output int                                      answers_seen
);

	typedef struct packed {
		logic signed [lemq_pkg::VAL_W-1:0] value;
		logic [lemq_pkg::IDX_W-1:0]        best;
		logic [1:0]                        code;
		logic [lemq_pkg::CNT_W-1:0]        size;
	} answer_t;

	// Expected results wait here in transfer order until the output side takes them.
	answer_t answer_fifo[1024];
	int unsigned fifo_wr;
	int unsigned fifo_rd;
	logic signed [31:0] hull_slope[lemq_pkg::LINE_SLOTS];
	logic signed [31:0] hull_offset[lemq_pkg::LINE_SLOTS];
	logic signed [31:0] hull_start[lemq_pkg::LINE_SLOTS];
	int unsigned hull_depth;
	int unsigned scan_pos;

	function automatic logic signed [31:0] crossing(logic signed [31:0] m_top,
			logic signed [31:0] c_top, logic signed [31:0] m_new, logic signed [31:0] c_new);
		longint num, den, q;
		num = (longint'(c_top) - longint'(c_new)) * (64'sd1 <<< lemq_pkg::FRAC_BITS);
		den = longint'(m_new) - longint'(m_top);
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic logic signed [63:0] height(int unsigned k, logic signed [31:0] x);
		return longint'(hull_slope[k]) * longint'(x) +
			longint'(hull_offset[k]) * (64'sd1 <<< lemq_pkg::FRAC_BITS);
	endfunction

	function automatic answer_t envelope_step(logic [1:0] md, logic signed [31:0] m,
			logic signed [31:0] c, logic signed [31:0] x);
		answer_t a;
		int unsigned d, lo, hi, mid;
		logic signed [31:0] st, xi;
		a = '0;
		if (md == lemq_pkg::MODE_ADD) begin
			if (hull_depth > 0 && m <= hull_slope[hull_depth-1]) begin
				a.code = lemq_pkg::ST_SLOPE;
			end else begin
				d = hull_depth;
				st = 32'sh80000000;
				while (d > 0) begin
					xi = crossing(hull_slope[d-1], hull_offset[d-1], m, c);
					if (hull_start[d-1] <= xi) begin
						st = xi;
						break;
					end
					d--;
				end
				if (d >= lemq_pkg::LINE_SLOTS) begin
					a.code = lemq_pkg::ST_FULL;
				end else begin
					hull_slope[d] = m;
					hull_offset[d] = c;
					hull_start[d] = st;
					hull_depth = d + 1;
					a.best = lemq_pkg::IDX_W'(d);
				end
			end
		end else if (md == lemq_pkg::MODE_SEARCH || md == lemq_pkg::MODE_SCAN) begin
			if (hull_depth == 0) begin
				a.code = lemq_pkg::ST_EMPTY;
			end else if (md == lemq_pkg::MODE_SEARCH) begin
				lo = 0;
				hi = hull_depth;
				while (lo + 1 < hi) begin
					mid = (lo + hi) / 2;
					if (hull_start[mid] <= x)
						lo = mid;
					else
						hi = mid;
				end
				a.best = lemq_pkg::IDX_W'(lo);
				a.value = height(lo, x);
			end else begin
				if (scan_pos > hull_depth - 1)
					scan_pos = hull_depth - 1;
				while (scan_pos + 1 < hull_depth && hull_start[scan_pos+1] <= x)
					scan_pos++;
				a.best = lemq_pkg::IDX_W'(scan_pos);
				a.value = height(scan_pos, x);
			end
		end
		a.size = lemq_pkg::CNT_W'(hull_depth);
		return a;
	endfunction

	answer_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hull_depth = 0;
			scan_pos = 0;
			fifo_wr = 0;
			fifo_rd = 0;
			fail_count <= 0;
			answers_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				answers_seen <= answers_seen + 1;
				if (fifo_wr == fifo_rd) begin
					$display("%0t: result with nothing expected: value %h best %0d status %0d size %0d",
						$time, envelope_value, best_line, status, hull_size);
					fail_count <= fail_count + 1;
				end else begin
					want = answer_fifo[fifo_rd[9:0]];
					fifo_rd = fifo_rd + 1;
					if (want.value !== envelope_value || want.best !== best_line ||
							want.code !== status || want.size !== hull_size) begin
						$display("%0t: mismatch expected value %h best %0d status %0d size %0d",
							$time, want.value, want.best, want.code, want.size);
						$display("%0t:          actual   value %h best %0d status %0d size %0d",
							$time, envelope_value, best_line, status, hull_size);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				answer_fifo[fifo_wr[9:0]] = envelope_step(mode, slope, intercept, query_x);
				fifo_wr = fifo_wr + 1;
			end
		end
	end

	assign pending = int'(fifo_wr - fifo_rd);
endmodule

`default_nettype wire

### sim/line_envelope_max_query_test.sv
// Testbench top for the line envelope maximum query block: drives stimulus
// with random gaps and stalls and reports the verdict.
// Depends on lemq_pkg, line_envelope_max_query and its checker.
`default_nettype none

module line_envelope_max_query_test;

	// The fourth mode code has no operation and must leave the hull alone.
	localparam logic [1:0] MODE_NOP = 2'd3;

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	logic [1:0] mode;
	logic signed [31:0] slope, intercept, query_x;
	logic signed [63:0] envelope_value;
	logic [7:0] best_line;
	logic [1:0] status;
	logic [8:0] hull_size;
	int fail_count, pending, answers_seen, adds, queries, fills;
	longint cycles;

	line_envelope_max_query dut (.*);
	line_envelope_max_query_checker watch (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: hold stall for a random count of cycles, then release for one transfer.
	initial begin
		int w;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			out_stall = (w != 0);
			repeat (w) @(negedge clk);
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send(logic [1:0] md, logic signed [31:0] m, logic signed [31:0] c,
			logic signed [31:0] x, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 14) : 0;
		repeat (w) @(negedge clk);
		mode = md;
		slope = m;
		intercept = c;
		query_x = x;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
		if (md == lemq_pkg::MODE_ADD) adds++; else queries++;
	endtask

	function automatic logic signed [31:0] any32();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 200))) - 100;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic signed [31:0] m, x;
		int n;
		cycles = 0;
		in_valid = 0;
		mode = lemq_pkg::MODE_ADD;
		slope = 0;
		intercept = 0;
		query_x = 0;
		adds = 0;
		queries = 0;
		fills = 0;
		arst_n = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		// Directed: queries on an empty hull, unused mode, extremes, rejected slopes.
		send(lemq_pkg::MODE_SEARCH, 0, 0, 5, 0);
		send(lemq_pkg::MODE_SCAN, 0, 0, 32'sh7fffffff, 0);
		send(MODE_NOP, 1, 2, 3, 0);
		send(lemq_pkg::MODE_ADD, 32'sh80000000, 32'sh7fffffff, 0, 0);
		send(lemq_pkg::MODE_ADD, 32'sh80000000, 0, 0, 0);
		send(lemq_pkg::MODE_ADD, -5, 32'sh80000000, 0, 0);
		send(lemq_pkg::MODE_ADD, 0, 0, 0, 0);
		send(lemq_pkg::MODE_ADD, 32'sh7fffffff, 32'sh7fffffff, 0, 1);
		send(lemq_pkg::MODE_ADD, 32'sh7fffffff, 0, 0, 0);
		send(lemq_pkg::MODE_SEARCH, 0, 0, 32'sh80000000, 1);
		send(lemq_pkg::MODE_SEARCH, 0, 0, 32'sh7fffffff, 0);
		send(lemq_pkg::MODE_SEARCH, 0, 0, 0, 0);
		send(lemq_pkg::MODE_SCAN, 0, 0, 32'sh80000000, 1);
		send(lemq_pkg::MODE_SCAN, 0, 0, 0, 0);
		send(lemq_pkg::MODE_SCAN, 0, 0, 32'sh7fffffff, 0);
		send(lemq_pkg::MODE_SCAN, 0, 0, -1, 0);
		send(MODE_NOP, -1, -1, -1, 1);
		// Random: ascending-slope sequences with query bursts; one long run tries to fill the store.
		while (adds + queries < 540) begin
			m = 32'sh80000000 + $urandom_range(0, 1000);
			x = 32'sh80000000 + $urandom_range(0, 1000);
			if (fills == 0 && adds > 150) begin
				n = 262;
				fills++;
			end else begin
				n = $urandom_range(1, 14);
			end
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					send(lemq_pkg::MODE_ADD, $urandom_range(0, 1) ? any32() : m,
						any32(), any32(), 1);
				else begin
					m = m + $urandom_range(1, n > 50 ? 1000 : 1 << $urandom_range(0, 28));
					send(lemq_pkg::MODE_ADD, m, any32(), any32(), n < 50);
				end
			end
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 6))
					0: send(lemq_pkg::MODE_SEARCH, any32(), any32(), any32(), 1);
					1: send(MODE_NOP, any32(), any32(), any32(), 1);
					2, 3: send(lemq_pkg::MODE_SEARCH, any32(), any32(), x, 1);
					default: begin
						x = x + $urandom_range(0, 1 << $urandom_range(0, 30));
						send(lemq_pkg::MODE_SCAN, any32(), any32(),
							$urandom_range(0, 7) == 0 ? any32() : x, 1);
					end
				endcase
			end
		end
		while (pending != 0) @(negedge clk);
		repeat (3000) @(negedge clk);
		$display("Covered %0d line adds and %0d queries, %0d results checked.",
			adds, queries, answers_seen);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

`default_nettype wire
